// ----- rtl/cspd_pkg.sv -----
`timescale 1ns / 1ps

package cspd_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int MAX_RDIV     = 7;
  localparam int CH_W         = 2;
  localparam int FREQ_W       = 29;
  localparam int XTAL_W       = 26;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int WORD_W       = 32;
  localparam int DIVR_W       = 9;
  localparam int RDIV_W       = 3;
  localparam int DRIVE_W      = 2;

  // device register map
  localparam logic [7:0] CTRL_BASE      = 8'd16;
  localparam logic [7:0] PLL_A_BASE     = 8'd26;
  localparam logic [7:0] PLL_B_BASE     = 8'd34;
  localparam logic [7:0] MS_BASE        = 8'd42;
  localparam logic [7:0] PLL_RESET_ADDR = 8'd177;
  localparam logic [7:0] CTRL_ON        = 8'h4C;
  localparam logic [7:0] CTRL_OFF       = 8'h80;
  localparam logic [7:0] CTRL_PLLB_SEL  = 8'h20;
  localparam logic [7:0] RST_PLL_A      = 8'h20;
  localparam logic [7:0] RST_PLL_B      = 8'h80;
  localparam logic [7:0] MS_BY4         = 8'h0C;
  localparam logic [31:0] HALVE_LIMIT   = 32'd300;
  localparam logic [31:0] P1_OFFSET     = 32'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRYSTAL    = 3'd0,
    CFG_VCO_LOW    = 3'd1,
    CFG_VCO_HIGH   = 3'd2,
    CFG_VCO_TARGET = 3'd3,
    CFG_DRIVE0     = 3'd4,
    CFG_DRIVE1     = 3'd5,
    CFG_DRIVE2     = 3'd6
  } cfg_idx_e;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_MUL_PLL  = 9'b000000010,
    S_DIV_TGT  = 9'b000000100,
    S_HALVE    = 9'b000001000,
    S_DIV_XTAL = 9'b000010000,
    S_DIV_FRAC = 9'b000100000,
    S_MUL_CT   = 9'b001000000,
    S_EMIT     = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_e;

endpackage

// ----- rtl/cspd_if.sv -----
`timescale 1ns / 1ps

interface cspd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic [28:0] target_hz;
  modport source (output valid, channel, target_hz, input ready);
  modport sink (input valid, channel, target_hz, output ready);
endinterface

interface cspd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;
  logic       last_write;
  modport source (output valid, reg_addr, reg_data, last_write, input ready);
  modport sink (input valid, reg_addr, reg_data, last_write, output ready);
endinterface

// ----- rtl/clock_synth_divider_planner.sv -----
`timescale 1ns / 1ps

// Channel     | Dir | Transaction
// in_if       | in  | channel, target_hz request
// out_if      | out | reg_addr, reg_data, last_write register write
// cfg_*       | in  | register index and data, one write per cycle
//
// A new divider costs three multiplies, three divides and a halving loop,
// then up to 18 register writes, one per cycle while the output is not stalled.
// Reusing the stored divider costs two multiplies and two divides plus 8 writes.
// Unchanged or out-of-range channel requests are accepted with no register write.
// Reset clears stored divider state and restores register defaults.
// A stalled output holds the sequencer in its write phase.
module clock_synth_divider_planner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cspd_in_if.sink                           in_if,
  cspd_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [cspd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cspd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import cspd_pkg::*;

  // configuration registers
  logic [XTAL_W-1:0]  crystal_q;
  logic [WORD_W-1:0]  vco_low_q, vco_high_q, vco_target_q;
  logic [DRIVE_W-1:0] drive_q [NUM_CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crystal_q    <= 26'd25000000;
      vco_low_q    <= 32'd600000000;
      vco_high_q   <= 32'd900000000;
      vco_target_q <= 32'd750000000;
      for (int i = 0; i < NUM_CHANNELS; i++) drive_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CRYSTAL:    crystal_q    <= cfg_wdata_i[XTAL_W-1:0];
        CFG_VCO_LOW:    vco_low_q    <= cfg_wdata_i;
        CFG_VCO_HIGH:   vco_high_q   <= cfg_wdata_i;
        CFG_VCO_TARGET: vco_target_q <= cfg_wdata_i;
        CFG_DRIVE0:     drive_q[0]   <= cfg_wdata_i[DRIVE_W-1:0];
        CFG_DRIVE1:     drive_q[1]   <= cfg_wdata_i[DRIVE_W-1:0];
        CFG_DRIVE2:     drive_q[2]   <= cfg_wdata_i[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e             state_q, state_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [FREQ_W-1:0]  f_q, f_d;
  logic [WORD_W-1:0]  div_q, div_d, pll_q, pll_d, t_q, t_d;
  logic [4:0]         rdiv_q, rdiv_d;
  logic               new_q, new_d, dis_q, dis_d, chg_q, chg_d;
  logic [7:0]         a_q, a_d;
  logic [26:0]        b_q, b_d;
  logic [17:0]        p1_q, p1_d;
  logic [19:0]        p2_q, p2_d;
  logic [4:0]         idx_q, idx_d;
  logic               mul_start_q, mul_start_d, div_start_q, div_start_d;

  logic [FREQ_W-1:0]  sfreq_q [NUM_CHANNELS];
  logic [DIVR_W-1:0]  sdiv_q  [NUM_CHANNELS];
  logic [RDIV_W-1:0]  srdiv_q [NUM_CHANNELS];
  logic               sfreq_we, sdiv_we;
  logic [DIVR_W-1:0]  sdiv_wd;
  logic [RDIV_W-1:0]  srdiv_wd;

  logic               ovalid_q, ovalid_d, olast_q, olast_d;
  logic [7:0]         oaddr_q, oaddr_d, odata_q, odata_d;

  // arithmetic units
  logic [WORD_W-1:0] mul_a, mul_b, mul_p, div_n, div_dn, div_quo, div_rem;
  logic              mul_busy, mul_done, div_busy, div_done;

  always_comb begin
    mul_a = {{(WORD_W-FREQ_W){1'b0}}, f_q};
    mul_b = div_q;
    if (state_q == S_MUL_CT) begin
      mul_a = {11'b0, crystal_q[XTAL_W-1:5]};
      mul_b = t_q;
    end
  end

  always_comb begin
    div_n  = vco_target_q;
    div_dn = {{(WORD_W-FREQ_W){1'b0}}, f_q};
    if (state_q == S_DIV_XTAL) begin
      div_n  = pll_q;
      div_dn = {{(WORD_W-XTAL_W){1'b0}}, crystal_q};
    end else if (state_q == S_DIV_FRAC) begin
      div_n  = {b_q[24:0], 7'b0};
      div_dn = {11'b0, crystal_q[XTAL_W-1:5]};
    end
  end

  cspd_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start_q), .a_i(mul_a), .b_i(mul_b),
    .busy_o(mul_busy), .done_o(mul_done), .prod_o(mul_p)
  );

  cspd_div u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .num_i(div_n), .den_i(div_dn),
    .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  // write byte selection
  logic [7:0]  pll_base, ms_addr, ctrl_byte, ms_byte2, byte_addr, byte_data;
  logic [17:0] p1m;
  logic [4:0]  last_idx;
  logic [20:0] c_val;

  assign c_val     = crystal_q[XTAL_W-1:5];
  assign pll_base  = (ch_q != '0) ? PLL_B_BASE : PLL_A_BASE;
  assign ms_addr   = MS_BASE + {3'b0, ch_q, 3'b0} + {3'b0, idx_q - 5'd8};
  assign ctrl_byte = CTRL_ON | {6'b0, drive_q[ch_q]}
                     | ((ch_q != '0) ? CTRL_PLLB_SEL : 8'h00);
  assign p1m       = {2'b0, div_q[DIVR_W-1:0], 7'b0} - P1_OFFSET[17:0];
  assign ms_byte2  = {6'b0, p1m[17:16]} | {1'b0, rdiv_q[2:0], 4'b0}
                     | ((div_q == 32'd4) ? MS_BY4 : 8'h00);
  assign last_idx  = chg_q ? 5'd17 : 5'd7;

  always_comb begin
    byte_addr = pll_base + {3'b0, idx_q};
    byte_data = 8'h00;
    unique case (idx_q)
      5'd0:  byte_data = c_val[15:8];
      5'd1:  byte_data = c_val[7:0];
      5'd2:  byte_data = {6'b0, p1_q[17:16]};
      5'd3:  byte_data = p1_q[15:8];
      5'd4:  byte_data = p1_q[7:0];
      5'd5:  byte_data = {c_val[19:16], p2_q[19:16]};
      5'd6:  byte_data = p2_q[15:8];
      5'd7:  byte_data = p2_q[7:0];
      5'd8, 5'd13, 5'd14, 5'd15: begin
        byte_addr = ms_addr;
        byte_data = 8'h00;
      end
      5'd9: begin
        byte_addr = ms_addr;
        byte_data = 8'h01;
      end
      5'd10: begin
        byte_addr = ms_addr;
        byte_data = ms_byte2;
      end
      5'd11: begin
        byte_addr = ms_addr;
        byte_data = p1m[15:8];
      end
      5'd12: begin
        byte_addr = ms_addr;
        byte_data = p1m[7:0];
      end
      5'd16: begin
        byte_addr = CTRL_BASE + {6'b0, ch_q};
        byte_data = ctrl_byte;
      end
      5'd17: begin
        byte_addr = PLL_RESET_ADDR;
        byte_data = (ch_q != '0) ? RST_PLL_B : RST_PLL_A;
      end
      default: ;
    endcase
    if (dis_q) begin
      byte_addr = CTRL_BASE + {6'b0, ch_q};
      byte_data = CTRL_OFF;
    end
  end

  // sequencer
  logic        in_acc, ch_ok, same_f, in_range, out_free;
  logic [WORD_W-1:0] pll_now;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign ch_ok       = {30'b0, in_if.channel} < NUM_CHANNELS;
  assign same_f      = ch_ok && (in_if.target_hz == sfreq_q[in_if.channel]);
  assign pll_now     = mul_p << rdiv_q;
  assign in_range    = !(pll_now < vco_low_q || pll_now > vco_high_q);
  assign out_free    = !ovalid_q || out_if.ready;

  always_comb begin
    state_d = state_q;  ch_d = ch_q;  f_d = f_q;  div_d = div_q;
    pll_d = pll_q;  t_d = t_q;  rdiv_d = rdiv_q;  new_d = new_q;
    dis_d = dis_q;  chg_d = chg_q;  a_d = a_q;  b_d = b_q;
    p1_d = p1_q;  p2_d = p2_q;  idx_d = idx_q;
    mul_start_d = 1'b0;  div_start_d = 1'b0;
    sfreq_we = 1'b0;  sdiv_we = 1'b0;  sdiv_wd = '0;  srdiv_wd = srdiv_q[ch_q];
    ovalid_d = ovalid_q && !out_if.ready;
    oaddr_d = oaddr_q;  odata_d = odata_q;  olast_d = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && ch_ok && !same_f) begin
          ch_d  = in_if.channel;
          f_d   = in_if.target_hz;
          dis_d = 1'b0;
          idx_d = '0;
          sfreq_we = 1'b1;
          if (in_if.target_hz == '0) begin
            dis_d   = 1'b1;
            sdiv_we = 1'b1;
            state_d = S_EMIT;
          end else begin
            div_d  = {23'b0, sdiv_q[in_if.channel]};
            rdiv_d = {2'b0, srdiv_q[in_if.channel]};
            new_d  = 1'b0;
            mul_start_d = 1'b1;
            state_d = S_MUL_PLL;
          end
        end
      end
      S_MUL_PLL: begin
        if (mul_done) begin
          pll_d = pll_now;
          if (new_q || in_range) begin
            div_start_d = 1'b1;
            state_d = S_DIV_XTAL;
          end else begin
            div_start_d = 1'b1;
            state_d = S_DIV_TGT;
          end
        end
      end
      S_DIV_TGT: begin
        if (div_done) begin
          rdiv_d = '0;
          if (div_quo < 32'd4) begin
            dis_d = 1'b1;  sdiv_we = 1'b1;  state_d = S_EMIT;
          end else begin
            div_d = (div_quo < 32'd6) ? 32'd4 : div_quo;
            state_d = S_HALVE;
          end
        end
      end
      S_HALVE: begin
        if (div_q > HALVE_LIMIT) begin
          div_d  = div_q >> 1;
          rdiv_d = rdiv_q + 5'd1;
        end else if (rdiv_q > 5'(MAX_RDIV)) begin
          dis_d = 1'b1;  sdiv_we = 1'b1;  state_d = S_EMIT;
        end else begin
          if (rdiv_q == '0) div_d = {div_q[WORD_W-1:1], 1'b0};
          new_d = 1'b1;
          mul_start_d = 1'b1;
          state_d = S_MUL_PLL;
        end
      end
      S_DIV_XTAL: begin
        if (div_done) begin
          a_d = div_quo[7:0];
          b_d = div_rem[WORD_W-1:5];
          div_start_d = 1'b1;
          state_d = S_DIV_FRAC;
        end
      end
      S_DIV_FRAC: begin
        if (div_done) begin
          t_d = div_quo;
          mul_start_d = 1'b1;
          state_d = S_MUL_CT;
        end
      end
      S_MUL_CT: begin
        if (mul_done) begin
          p1_d  = 18'({24'b0, a_q} * 32'd128 + t_q - P1_OFFSET);
          p2_d  = 20'({b_q[24:0], 7'b0} - mul_p);
          chg_d = (div_q[DIVR_W-1:0] != sdiv_q[ch_q])
                  || (rdiv_q[RDIV_W-1:0] != srdiv_q[ch_q]);
          if (chg_d) begin
            sdiv_we  = 1'b1;
            sdiv_wd  = div_q[DIVR_W-1:0];
            srdiv_wd = rdiv_q[RDIV_W-1:0];
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oaddr_d  = byte_addr;
          odata_d  = byte_data;
          olast_d  = dis_q || (idx_q == last_idx);
          idx_d    = idx_q + 5'd1;
          if (olast_d) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      ovalid_q    <= 1'b0;
      dis_q       <= 1'b0;
      chg_q       <= 1'b0;
      new_q       <= 1'b0;
      idx_q       <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sfreq_q[i] <= '0;
        sdiv_q[i]  <= '0;
        srdiv_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      mul_start_q <= mul_start_d;
      div_start_q <= div_start_d;
      ovalid_q    <= ovalid_d;
      dis_q       <= dis_d;
      chg_q       <= chg_d;
      new_q       <= new_d;
      idx_q       <= idx_d;
      if (sfreq_we) sfreq_q[ch_d] <= f_d;
      if (sdiv_we) begin
        sdiv_q[ch_d] <= sdiv_wd;
        if (!dis_d) srdiv_q[ch_d] <= srdiv_wd;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;  f_q <= f_d;  div_q <= div_d;  pll_q <= pll_d;
    t_q <= t_d;  rdiv_q <= rdiv_d;  a_q <= a_d;  b_q <= b_d;
    p1_q <= p1_d;  p2_q <= p2_d;
    oaddr_q <= oaddr_d;  odata_q <= odata_d;  olast_q <= olast_d;
  end

  assign out_if.valid      = ovalid_q;
  assign out_if.reg_addr   = oaddr_q;
  assign out_if.reg_data   = odata_q;
  assign out_if.last_write = olast_q;

`ifndef SYNTHESIS
  a_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_busy |-> (state_q == S_MUL_PLL || state_q == S_MUL_CT))
    else $error("multiplier busy outside a multiply step");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_DIV_TGT || state_q == S_DIV_XTAL
                  || state_q == S_DIV_FRAC))
    else $error("divider busy outside a divide step");
  a_div_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !dis_q) |-> div_q <= HALVE_LIMIT)
    else $error("divider exceeds limit during write phase");
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && (dis_q || idx_q == last_idx))
    |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after last write");
`endif

endmodule

// ----- rtl/cspd_mul.sv -----
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle, low word kept.
module cspd_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [cspd_pkg::WORD_W-1:0] a_i,
  input  logic [cspd_pkg::WORD_W-1:0] b_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [cspd_pkg::WORD_W-1:0] prod_o
);
  import cspd_pkg::*;

  logic [WORD_W-1:0] acc_q, mcand_q, mplier_q;
  logic [5:0]        cnt_q;
  logic              busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(WORD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= a_i;
      mplier_q <= b_i;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= {mcand_q[WORD_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[WORD_W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/cspd_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. A zero divisor gives
// an all-ones quotient and the dividend as remainder.
module cspd_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [cspd_pkg::WORD_W-1:0] num_i,
  input  logic [cspd_pkg::WORD_W-1:0] den_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [cspd_pkg::WORD_W-1:0] quo_o,
  output logic [cspd_pkg::WORD_W-1:0] rem_o
);
  import cspd_pkg::*;

  logic [WORD_W:0]   rem_q, rem_sh, rem_sub;
  logic [WORD_W-1:0] quo_q, den_q;
  logic [5:0]        cnt_q;
  logic              busy_q, done_q, ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(WORD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one trial subtract per cycle
  assign rem_sh  = {rem_q[WORD_W-1:0], quo_q[WORD_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub : rem_sh;
      quo_q <= {quo_q[WORD_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[WORD_W-1:0];

endmodule
